// ===== src/motion_burst_counter_assert.svh =====
// Assertion macros for the motion burst counter.
`ifndef MOTION_BURST_COUNTER_ASSERT_SVH
`define MOTION_BURST_COUNTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check that cons holds in the same cycle as ante.
`define MBC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that cons holds in the cycle after ante.
`define MBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MBC_ASSERT_SAME(label, ante, cons, msg)
`define MBC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== src/mbc_pkg.sv =====
// Shared types and constants of the motion burst counter.
`timescale 1ns / 1ps
package mbc_pkg;
	localparam int unsigned AccelW  = 16;
	localparam int unsigned ThreshW = 16;
	localparam int unsigned RangeW  = 8;
	localparam int unsigned TicksW  = 16;
	localparam int unsigned CountW  = 8;
	localparam int unsigned DeltaW  = AccelW + 1;
	localparam int unsigned UpperW  = ThreshW + RangeW;
	localparam int unsigned CfgW    = 16;
	localparam int unsigned Axes    = 3;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_THRESHOLD = 2'd0;
	localparam cfg_idx_t CFG_RANGE     = 2'd1;
	localparam cfg_idx_t CFG_WINDOW    = 2'd2;

	localparam logic [ThreshW-1:0] THRESHOLD_RST = 16'd7;
	localparam logic [RangeW-1:0]  RANGE_RST     = 8'd7;
	localparam logic [TicksW-1:0]  WINDOW_RST    = 16'd1000;
	localparam logic [CountW-1:0]  COUNT_MAX     = 8'd255;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	typedef logic [Axes-1:0][AccelW-1:0] axes_t;

	typedef struct packed {
		logic [ThreshW-1:0] threshold;
		logic [RangeW-1:0]  range_factor;
		logic [TicksW-1:0]  window_ticks;
	} cfg_t;

	typedef struct packed {
		logic over_any;
		logic under_upper_any;
		logic under_all;
	} flags_t;

	typedef struct packed {
		logic              movement_seen;
		logic              window_done;
		logic [CountW-1:0] reported_count;
		logic              detector_armed;
	} res_t;
endpackage

// ===== src/mbc_if.sv =====
// Channel interfaces for sample/tick words and result words.
`timescale 1ns / 1ps
interface mbc_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [15:0] first_x;
	logic [15:0] first_y;
	logic [15:0] first_z;
	logic [15:0] second_x;
	logic [15:0] second_y;
	logic [15:0] second_z;
	modport source (output valid, op, first_x, first_y, first_z,
		second_x, second_y, second_z, input ready);
	modport sink (input valid, op, first_x, first_y, first_z,
		second_x, second_y, second_z, output ready);
endinterface

interface mbc_out_if;
	logic       valid;
	logic       ready;
	logic       movement_seen;
	logic       window_done;
	logic [7:0] reported_count;
	logic       detector_armed;
	modport source (output valid, movement_seen, window_done, reported_count,
		detector_armed, input ready);
	modport sink (input valid, movement_seen, window_done, reported_count,
		detector_armed, output ready);
endinterface

// ===== src/mbc_delta.sv =====
// Per-axis absolute differences and their compares against the thresholds.
`timescale 1ns / 1ps
module mbc_delta (
	input  mbc_pkg::axes_t  first,
	input  mbc_pkg::axes_t  second,
	input  mbc_pkg::cfg_t   cfg,
	output mbc_pkg::flags_t flags
);
	import mbc_pkg::*;

	logic [UpperW-1:0] upper;
	logic [Axes-1:0][DeltaW-1:0] delta;
	logic [Axes-1:0] over, under_up, under_th;

	// Form the upper bound as the exact product.
	assign upper = UpperW'(cfg.threshold) * UpperW'(cfg.range_factor);

	// Take the magnitude of each axis difference and compare it.
	always_comb begin
		logic signed [DeltaW-1:0] diff;
		for (int i = 0; i < Axes; i++) begin
			diff = DeltaW'($signed(second[i])) - DeltaW'($signed(first[i]));
			delta[i] = diff[DeltaW-1] ? DeltaW'(-diff) : DeltaW'(diff);
			over[i] = delta[i] > DeltaW'(cfg.threshold);
			under_th[i] = delta[i] < DeltaW'(cfg.threshold);
			under_up[i] = UpperW'(delta[i]) < upper;
		end
	end

	assign flags.over_any        = |over;
	assign flags.under_upper_any = |under_up;
	assign flags.under_all       = &under_th;
endmodule

// ===== src/mbc_ctrl.sv =====
// Detector and window state, updated once per word.
`timescale 1ns / 1ps
module mbc_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     fire,
	input  logic                     op,
	input  mbc_pkg::flags_t          flags,
	input  mbc_pkg::cfg_t            cfg,
	output mbc_pkg::res_t            res,
	output logic                     running,
	output logic [mbc_pkg::TicksW-1:0] ticks_left,
	output logic [mbc_pkg::CountW-1:0] count
);
	import mbc_pkg::*;

	logic              armed_q, armed_d;
	logic              running_q, running_d;
	logic [TicksW-1:0] ticks_q, ticks_d;
	logic [CountW-1:0] count_q, count_d;
	logic              hit;

	// Work out the next state and the result for the word in stage one.
	always_comb begin
		armed_d   = armed_q;
		running_d = running_q;
		ticks_d   = ticks_q;
		count_d   = count_q;
		res       = '0;
		hit       = armed_q & flags.over_any & flags.under_upper_any;
		unique case (op)
			OP_SAMPLE: begin
				if (hit) begin
					if (!running_q) begin
						running_d = 1'b1;
						ticks_d   = cfg.window_ticks;
					end
					armed_d = 1'b0;
					if (count_q != COUNT_MAX) count_d = count_q + 1'b1;
					res.movement_seen = 1'b1;
				end
				if (flags.under_all) armed_d = 1'b1;
			end
			OP_TICK: begin
				if (running_q) begin
					if (ticks_q <= TicksW'(1)) begin
						ticks_d   = '0;
						running_d = 1'b0;
						armed_d   = 1'b1;
						count_d   = '0;
						res.window_done    = 1'b1;
						res.reported_count = count_q;
					end else begin
						ticks_d = ticks_q - 1'b1;
					end
				end
			end
			default: ;
		endcase
		res.detector_armed = armed_d;
	end

	// Commit the state when the word leaves stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q   <= 1'b1;
			running_q <= 1'b0;
			ticks_q   <= '0;
			count_q   <= '0;
		end else if (fire) begin
			armed_q   <= armed_d;
			running_q <= running_d;
			ticks_q   <= ticks_d;
			count_q   <= count_d;
		end
	end

	assign running    = running_q;
	assign ticks_left = ticks_q;
	assign count      = count_q;
endmodule

// ===== src/motion_burst_counter.sv =====
// An accepted word waits in the stage-one register and moves to the result register unless the result stalls.
// Throughput: one word per cycle while results are taken; the input register and the result register
// let a new word in while a finished result still waits.
// Reset (arst_n low, asynchronous): channels empty, detector armed, no window,
// count zero, registers at threshold 7, range factor 7, window 1000 ticks.
`timescale 1ns / 1ps
module motion_burst_counter (
	input  logic                    clk,
	input  logic                    arst_n,
	mbc_in_if.sink                  item,
	mbc_out_if.source               result,
	input  logic                    cfg_we,
	input  mbc_pkg::cfg_idx_t       cfg_index,
	input  logic [mbc_pkg::CfgW-1:0] cfg_data
);
	import mbc_pkg::*;

	`include "motion_burst_counter_assert.svh"

	cfg_t              cfg_q;
	logic              valid_s1;
	logic              op_s1;
	axes_t             first_s1, second_s1;
	logic              out_valid_q;
	res_t              out_q;
	logic              adv_out, fire;
	flags_t            flags;
	res_t              res;
	logic              running;
	logic [TicksW-1:0] ticks_left;
	logic [CountW-1:0] count;

	// Write configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold    <= THRESHOLD_RST;
			cfg_q.range_factor <= RANGE_RST;
			cfg_q.window_ticks <= WINDOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_THRESHOLD: cfg_q.threshold    <= cfg_data[ThreshW-1:0];
				CFG_RANGE:     cfg_q.range_factor <= cfg_data[RangeW-1:0];
				CFG_WINDOW:    cfg_q.window_ticks <= cfg_data[TicksW-1:0];
				default: ;
			endcase
		end
	end

	// Advance when the result register is empty or being drained.
	assign adv_out    = !out_valid_q || result.ready;
	assign fire       = valid_s1 && adv_out;
	assign item.ready = !valid_s1 || adv_out;

	// Hold the accepted word in stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			op_s1     <= item.op;
			first_s1  <= {item.first_z, item.first_y, item.first_x};
			second_s1 <= {item.second_z, item.second_y, item.second_x};
		end
	end

	mbc_delta u_delta (
		.first  (first_s1),
		.second (second_s1),
		.cfg    (cfg_q),
		.flags  (flags)
	);

	mbc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.op         (op_s1),
		.flags      (flags),
		.cfg        (cfg_q),
		.res        (res),
		.running    (running),
		.ticks_left (ticks_left),
		.count      (count)
	);

	// Load the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) out_q <= res;
	end

	assign result.valid          = out_valid_q;
	assign result.movement_seen  = out_q.movement_seen;
	assign result.window_done    = out_q.window_done;
	assign result.reported_count = out_q.reported_count;
	assign result.detector_armed = out_q.detector_armed;

	`MBC_ASSERT_SAME(a_idle_ticks, !running, ticks_left == '0, "ticks left without a window")
	`MBC_ASSERT_SAME(a_count_window, count != '0, running, "movement counted outside a window")
	`MBC_ASSERT_SAME(a_done_rearms, out_valid_q && out_q.window_done,
		out_q.detector_armed && !out_q.movement_seen, "window end did not re-arm")
	`MBC_ASSERT_NEXT(a_stall_holds, valid_s1 && !adv_out, valid_s1, "stalled word dropped")
endmodule
